[design/mnp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_pkg
// shared constants, codes and types of the markov next-item predictor
// ----------------------------------------------------------------------------
package mnp_pkg;

    localparam int MAX_NODES  = 64;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int NCNT_W     = NODE_W + 1;
    localparam int HIST_DEPTH = 8;
    localparam int HIST_W     = $clog2(HIST_DEPTH);
    localparam int HCNT_W     = HIST_W + 1;
    localparam int MAX_OUT    = 16;
    localparam int OCNT_W     = $clog2(MAX_OUT + 1);
    localparam int PROB_W     = 16;
    localparam int PROD_W     = 2 * PROB_W;
    localparam int SCORE_W    = 38;
    localparam int KEY_W      = 64;
    localparam int MAT_AW     = 2 * NODE_W;
    localparam int MAT_DEPTH  = MAX_NODES * MAX_NODES;

    // input field widths
    localparam int ACT_W      = 2;
    localparam int IN_NODE_W  = 6;
    localparam int IN_PROB_W  = 16;

    // configuration port
    localparam int CFG_IW     = 2;
    localparam int CFG_DW     = 7;
    localparam int NIU_W      = 7;
    localparam int KEEP_W     = 3;
    localparam int MAXP_W     = 5;

    localparam logic [CFG_IW-1:0] CFG_NODES_IN_USE    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_HISTORY_KEEP    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MAX_PREDICTIONS = 2'd2;

    localparam logic [ACT_W-1:0] ACT_WRITE_PROB = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_KEY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EVENT      = 2'd2;

    // one ranked entry of the top-score chain
    typedef struct packed {
        logic               vld;
        logic [NODE_W-1:0]  node;
        logic [SCORE_W-1:0] score;
    } entry_t;

    // chain-wide control
    typedef struct packed {
        logic clear;
        logic pop;
    } chain_ctl_t;

endpackage

[design/mnp_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface mnp_req_if;
    import mnp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [IN_NODE_W-1:0] row_node;
    logic [IN_NODE_W-1:0] column_node;
    logic [IN_PROB_W-1:0] probability;
    logic [KEY_W-1:0]     object_key;

    modport source (output valid, action, row_node, column_node, probability, object_key,
                    input ready);
    modport sink   (input valid, action, row_node, column_node, probability, object_key,
                    output ready);
endinterface

interface mnp_rsp_if;
    import mnp_pkg::*;
    logic               valid;
    logic               ready;
    logic               known;
    logic [5:0]         predicted_node;
    logic [SCORE_W-1:0] score;
    logic               last;

    modport source (output valid, known, predicted_node, score, last, input ready);
    modport sink   (input valid, known, predicted_node, score, last, output ready);
endinterface

[design/markov_next_item_predictor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_next_item_predictor
// markov next-node predictor: transition matrix, key lookup, ranked output
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    transaction
//  req      in   action, row_node, column_node, prob, key   valid & ready
//  rsp      out  known, predicted_node, score, last         valid & ready
//  cfg      in   cfg_index, cfg_data                        cfg_we
//
//  a write is stored in the cycle it is taken; an event runs a key search,
//  then (n-1) * (history count + 1) matrix reads at one per cycle, set by
//  the single matrix read port, drains the score pipeline and gives one
//  result per cycle while rsp is ready
//  after reset a clearing pass over all 4096 entries zeroes the matrix;
//  req is not ready until it ends
//  one item at a time; rsp stalls simply hold the head of the chain
// ----------------------------------------------------------------------------
module markov_next_item_predictor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mnp_pkg::CFG_IW-1:0] cfg_index,
    input  logic [mnp_pkg::CFG_DW-1:0] cfg_data,
    mnp_req_if.sink                    req,
    mnp_rsp_if.source                  rsp
);
    import mnp_pkg::*;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SRCH, S_UNK, S_SCORE, S_FLUSH, S_OUT, S_DONE
    } state_t;

    // pipeline tag traveling with each matrix read
    typedef struct packed {
        logic              vld;
        logic              first;   // scale read of the newest node row
        logic              firsth;  // oldest history term
        logic              lasth;   // newest history term, score complete
        logic [HCNT_W-1:0] weight;
        logic [NODE_W-1:0] node;
    } stag_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [NIU_W-1:0]  niu_reg;
    logic [KEEP_W-1:0] keep_reg;
    logic [MAXP_W-1:0] maxp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            niu_reg  <= NIU_W'(MAX_NODES);
            keep_reg <= KEEP_W'(3);
            maxp_reg <= MAXP_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NODES_IN_USE:    niu_reg  <= cfg_data[NIU_W-1:0];
                CFG_HISTORY_KEEP:    keep_reg <= cfg_data[KEEP_W-1:0];
                CFG_MAX_PREDICTIONS: maxp_reg <= cfg_data[MAXP_W-1:0];
                default: ;
            endcase
        end
    end

    // nodes taking part, saturated to the table size
    logic [NCNT_W-1:0] n_act;
    assign n_act = (NCNT_W'(niu_reg) > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                                                          : NCNT_W'(niu_reg);

    logic req_fire, rsp_fire;
    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;

    // key table: memory with registered read, valid bits in flops
    logic [KEY_W-1:0]     key_mem [MAX_NODES];
    logic [KEY_W-1:0]     krd_reg;
    logic [NODE_W-1:0]    kaddr;
    logic [MAX_NODES-1:0] kvalid_reg;
    logic                 key_we;

    assign key_we = req_fire && (req.action == ACT_WRITE_KEY);

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[req.row_node[NODE_W-1:0]] <= req.object_key;
        krd_reg <= key_mem[kaddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kvalid_reg <= '0;
        else if (key_we)
            kvalid_reg[req.row_node[NODE_W-1:0]] <= 1'b1;
    end

    // transition matrix: memory with one write and one registered read port, cleared by a sweep after reset
    logic [PROB_W-1:0] mat_mem [MAT_DEPTH];
    logic [PROB_W-1:0] mrd_reg;
    logic [MAT_AW-1:0] mat_raddr, mat_waddr;
    logic [PROB_W-1:0] mat_wdata;
    logic              mat_we;

    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_waddr] <= mat_wdata;
        mrd_reg <= mat_mem[mat_raddr];
    end

    // sequencer registers
    logic [MAT_AW-1:0]  clr_reg, clr_next;
    logic [KEY_W-1:0]   evkey_reg, evkey_next;
    logic [NCNT_W-1:0]  sidx_reg, sidx_next;     // key search issue index
    logic               kv_reg, kv_next;         // key read in flight
    logic [NODE_W-1:0]  kidx_reg, kidx_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;       // newest node
    logic [NODE_W-1:0]  hist_reg [HIST_DEPTH];
    logic [NODE_W-1:0]  hist_next [HIST_DEPTH];
    logic [HCNT_W-1:0]  hcnt_reg, hcnt_next;
    logic [NCNT_W-1:0]  i_reg, i_next;           // candidate node
    logic [HCNT_W-1:0]  s_reg, s_next;           // read step within a node
    logic [OCNT_W-1:0]  lim_reg, lim_next;
    logic [OCNT_W-1:0]  ocnt_reg, ocnt_next;

    // score pipeline
    stag_t              t1_reg, t1_next, t2_reg, t2_next;
    logic [PROB_W-1:0]  scale_reg, scale_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SCORE_W-1:0] acc_reg, acc_next;
    entry_t             cand_reg, cand_next;

    chain_ctl_t         cctl;
    entry_t             head;

    mnp_rank_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .cand  (cand_reg),
        .head  (head)
    );

    // weighted term and saturating sum
    logic [PROD_W+HCNT_W-1:0] wprod;
    logic [SCORE_W:0]         wsum;
    logic [SCORE_W-1:0]       wsat;
    assign wprod = (PROD_W + HCNT_W)'(prod_reg) * (PROD_W + HCNT_W)'(t2_reg.weight);
    assign wsum  = (t2_reg.firsth ? (SCORE_W + 1)'(0) : (SCORE_W + 1)'(acc_reg))
                 + (SCORE_W + 1)'(wprod);
    assign wsat  = wsum[SCORE_W] ? {SCORE_W{1'b1}} : wsum[SCORE_W-1:0];

    logic               kmatch;
    logic [NCNT_W-1:0]  lim_w;
    logic [KEEP_W-1:0]  keep_sat;
    logic [HIST_W-1:0]  hsel;

    assign kmatch   = kv_reg && kvalid_reg[kidx_reg] && (krd_reg == evkey_reg);
    assign keep_sat = (32'(keep_reg) > HIST_DEPTH - 1) ? KEEP_W'(HIST_DEPTH - 1) : keep_reg;
    assign hsel     = HIST_W'(s_reg - HCNT_W'(1));

    always_comb
    begin
        logic [NCNT_W-1:0] mp;
        state_next = state_reg;
        clr_next   = clr_reg;
        evkey_next = evkey_reg;
        sidx_next  = sidx_reg;
        kv_next    = 1'b0;
        kidx_next  = kidx_reg;
        cur_next   = cur_reg;
        hist_next  = hist_reg;
        hcnt_next  = hcnt_reg;
        i_next     = i_reg;
        s_next     = s_reg;
        lim_next   = lim_reg;
        ocnt_next  = ocnt_reg;
        kaddr      = sidx_reg[NODE_W-1:0];
        mat_we     = 1'b0;
        mat_waddr  = {req.row_node[NODE_W-1:0], req.column_node[NODE_W-1:0]};
        mat_wdata  = req.probability[PROB_W-1:0];
        mat_raddr  = {cur_reg, i_reg[NODE_W-1:0]};
        t1_next    = '0;
        cctl       = '0;
        req.ready  = 1'b0;
        rsp.valid  = 1'b0;
        rsp.known  = 1'b0;
        rsp.predicted_node = '0;
        rsp.score  = '0;
        rsp.last   = 1'b0;

        // result limit: min(max_predictions, MAX_OUT, candidates)
        mp    = NCNT_W'(maxp_reg);
        lim_w = (mp > NCNT_W'(MAX_OUT)) ? NCNT_W'(MAX_OUT) : mp;
        if (lim_w > n_act - NCNT_W'(1))
            lim_w = n_act - NCNT_W'(1);

        case (state_reg)
            S_CLR:
            begin
                mat_we    = 1'b1;
                mat_waddr = clr_reg;
                mat_wdata = '0;
                clr_next  = clr_reg + MAT_AW'(1);
                if (clr_reg == MAT_AW'(MAT_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req_fire)
                begin
                    case (req.action)
                        ACT_WRITE_PROB: mat_we = 1'b1;
                        ACT_EVENT:
                        begin
                            evkey_next = req.object_key;
                            sidx_next  = '0;
                            state_next = S_SRCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH:
            begin
                if (kmatch)
                begin
                    // append the matched node to the history
                    cur_next = kidx_reg;
                    if (hcnt_reg < HCNT_W'(HIST_DEPTH))
                    begin
                        hist_next[hcnt_reg[HIST_W-1:0]] = kidx_reg;
                        hcnt_next = hcnt_reg + HCNT_W'(1);
                    end
                    else
                    begin
                        for (int h = 0; h < HIST_DEPTH - 1; h++)
                            hist_next[h] = hist_reg[h+1];
                        hist_next[HIST_DEPTH-1] = kidx_reg;
                    end
                    lim_next   = OCNT_W'(lim_w);
                    i_next     = '0;
                    s_next     = '0;
                    cctl.clear = 1'b1;
                    state_next = S_SCORE;
                end
                else if (sidx_reg < n_act)
                begin
                    kv_next   = 1'b1;
                    kidx_next = sidx_reg[NODE_W-1:0];
                    sidx_next = sidx_reg + NCNT_W'(1);
                end
                else if (!kv_reg)
                begin
                    state_next = S_UNK;
                end
            end
            S_UNK:
            begin
                rsp.valid = 1'b1;
                rsp.last  = 1'b1;
                if (rsp_fire)
                    state_next = S_IDLE;
            end
            S_SCORE:
            begin
                if (i_reg >= n_act)
                begin
                    state_next = S_FLUSH;
                end
                else if (i_reg == NCNT_W'(cur_reg))
                begin
                    i_next = i_reg + NCNT_W'(1);
                end
                else
                begin
                    // step 0 reads the newest row, steps 1..count the history rows
                    if (s_reg != '0)
                        mat_raddr = {hist_reg[hsel], i_reg[NODE_W-1:0]};
                    t1_next.vld    = 1'b1;
                    t1_next.first  = (s_reg == '0);
                    t1_next.firsth = (s_reg == HCNT_W'(1));
                    t1_next.lasth  = (s_reg == hcnt_reg);
                    t1_next.weight = hcnt_reg - s_reg + HCNT_W'(1);
                    t1_next.node   = i_reg[NODE_W-1:0];
                    if (s_reg == hcnt_reg)
                    begin
                        s_next = '0;
                        i_next = i_reg + NCNT_W'(1);
                    end
                    else
                    begin
                        s_next = s_reg + HCNT_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (!t1_reg.vld && !t2_reg.vld && !cand_reg.vld)
                begin
                    ocnt_next  = '0;
                    state_next = (lim_reg == '0) ? S_DONE : S_OUT;
                end
            end
            S_OUT:
            begin
                rsp.valid          = 1'b1;
                rsp.known          = 1'b1;
                rsp.predicted_node = head.node;
                rsp.score          = head.score;
                rsp.last           = (ocnt_reg == lim_reg - OCNT_W'(1));
                if (rsp_fire)
                begin
                    cctl.pop  = 1'b1;
                    ocnt_next = ocnt_reg + OCNT_W'(1);
                    if (rsp.last)
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // trim one oldest entry beyond the kept length
                if (hcnt_reg > HCNT_W'(keep_sat))
                begin
                    for (int h = 0; h < HIST_DEPTH - 1; h++)
                        hist_next[h] = hist_reg[h+1];
                    hcnt_next = hcnt_reg - HCNT_W'(1);
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // score pipeline: product, then weighted accumulate, then candidate
    always_comb
    begin
        scale_next = scale_reg;
        prod_next  = prod_reg;
        t2_next    = '0;
        acc_next   = acc_reg;
        cand_next  = '0;
        if (t1_reg.vld)
        begin
            if (t1_reg.first)
            begin
                scale_next = mrd_reg;
            end
            else
            begin
                prod_next = PROD_W'(mrd_reg) * PROD_W'(scale_reg);
                t2_next   = t1_reg;
            end
        end
        if (t2_reg.vld)
        begin
            acc_next = wsat;
            if (t2_reg.lasth)
                cand_next = '{vld: 1'b1, node: t2_reg.node, score: wsat};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            sidx_reg  <= '0;
            kv_reg    <= 1'b0;
            hcnt_reg  <= '0;
            i_reg     <= '0;
            s_reg     <= '0;
            lim_reg   <= '0;
            ocnt_reg  <= '0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            cand_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sidx_reg  <= sidx_next;
            kv_reg    <= kv_next;
            hcnt_reg  <= hcnt_next;
            i_reg     <= i_next;
            s_reg     <= s_next;
            lim_reg   <= lim_next;
            ocnt_reg  <= ocnt_next;
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evkey_reg <= evkey_next;
        kidx_reg  <= kidx_next;
        cur_reg   <= cur_next;
        hist_reg  <= hist_next;
        scale_reg <= scale_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

`ifndef SYNTHESIS
    // an unknown key result is always the single empty one
    a_unknown_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.known |-> rsp.last && rsp.score == '0 && rsp.predicted_node == '0)
        else $error("unknown result carries payload");

    // every ranked result comes from a filled slot of the chain
    a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.known |-> head.vld)
        else $error("result from empty chain slot");

    // no new transaction while the score pipeline still holds work
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !t1_reg.vld && !t2_reg.vld && !cand_reg.vld)
        else $error("request taken with score pipeline busy");

    // history count stays within the history depth
    a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= HCNT_W'(HIST_DEPTH))
        else $error("history count overflow");
`endif
endmodule

[design/mnp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_cell
// one slot of the sorted top-score chain: insert, shift down, pop up
// ----------------------------------------------------------------------------
module mnp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mnp_pkg::chain_ctl_t ctl,
    input  mnp_pkg::entry_t     cand,
    input  logic                left_ins,
    input  mnp_pkg::entry_t     left,
    input  mnp_pkg::entry_t     right,
    output mnp_pkg::entry_t     own,
    output logic                ins
);
    import mnp_pkg::*;

    logic               vld_reg, vld_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [SCORE_W-1:0] score_reg, score_next;

    assign own = '{vld: vld_reg, node: node_reg, score: score_reg};
    // strict compare: equal scores keep the earlier (lower) node ahead
    assign ins = cand.vld && (!vld_reg || (cand.score > score_reg));

    always_comb
    begin
        vld_next   = vld_reg;
        node_next  = node_reg;
        score_next = score_reg;
        if (ctl.clear)
        begin
            vld_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            vld_next   = right.vld;
            node_next  = right.node;
            score_next = right.score;
        end
        else if (left_ins)
        begin
            vld_next   = left.vld;
            node_next  = left.node;
            score_next = left.score;
        end
        else if (ins)
        begin
            vld_next   = 1'b1;
            node_next  = cand.node;
            score_next = cand.score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        score_reg <= score_next;
    end
endmodule

[design/mnp_rank_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_rank_chain
// row of cells holding the best scores in descending order
// ----------------------------------------------------------------------------
module mnp_rank_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  mnp_pkg::chain_ctl_t ctl,
    input  mnp_pkg::entry_t     cand,
    output mnp_pkg::entry_t     head
);
    import mnp_pkg::*;

    entry_t ent [MAX_OUT];
    logic   ins [MAX_OUT];

    genvar k;
    generate
        for (k = 0; k < MAX_OUT; k++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_i;
            if (k == 0)
            begin : g_first
                assign left_e = '0;
                assign left_i = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = ent[k-1];
                assign left_i = ins[k-1];
            end
            if (k == MAX_OUT - 1)
            begin : g_end
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = ent[k+1];
            end
            mnp_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .cand     (cand),
                .left_ins (left_i),
                .left     (left_e),
                .right    (right_e),
                .own      (ent[k]),
                .ins      (ins[k])
            );
        end
    endgenerate

    assign head = ent[0];
endmodule
